### hdl/i2cmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmf_pkg
// Shared types and codes for the i2c slave mailbox framer.
// ----------------------------------------------------------------------------
package i2cmf_pkg;

  localparam int DEVICES_DEF      = 8;
  localparam int PACKET_BYTES_DEF = 15;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  // operations
  localparam logic [2:0] OP_WRITE_REQ  = 3'd0;
  localparam logic [2:0] OP_WRITE_DONE = 3'd1;
  localparam logic [2:0] OP_READ_REQ   = 3'd2;
  localparam logic [2:0] OP_READ_DONE  = 3'd3;
  localparam logic [2:0] OP_POST       = 3'd4;
  localparam logic [2:0] OP_RELEASE    = 3'd5;

  // host response kinds
  localparam logic [1:0] RESP_ACK      = 2'd0;
  localparam logic [1:0] RESP_DONE     = 2'd1;
  localparam logic [1:0] RESP_ACK_DONE = 2'd2;
  localparam logic [1:0] RESP_ERROR    = 2'd3;

  localparam logic [7:0] ACK_BYTE      = 8'h80;
  localparam logic [7:0] DONE_BYTE     = 8'h40;
  localparam logic [7:0] ACK_DONE_BYTE = 8'hC0;

  // result kinds
  localparam logic [1:0] RK_NONE    = 2'd0;
  localparam logic [1:0] RK_BUS     = 2'd1;
  localparam logic [1:0] RK_COMMAND = 2'd2;

  // event status
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BUSY    = 3'd1;
  localparam logic [2:0] ST_CKSUM   = 3'd2;
  localparam logic [2:0] ST_BAD_DEV = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;

  // config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BUSY_CODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CKSUM_CODE = 1'd1;

  localparam logic [7:0] BUSY_CODE_RST  = 8'd1;
  localparam logic [7:0] CKSUM_CODE_RST = 8'd2;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] bus_byte;
    logic [2:0] host_device;
    logic [1:0] response_kind;
    logic [7:0] host_error_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] read_data;
    logic [2:0] command_device;
    logic [3:0] command_index;
    logic [7:0] command_byte;
    logic       last;
    logic [2:0] event_status;
  } out_item_t;

  typedef struct packed {
    logic [7:0] byte1;
    logic [7:0] byte0;
    logic [3:0] chk;
  } resp_word_t;

  typedef enum logic [1:0] {
    ACT_NOTE,
    ACT_READ,
    ACT_EMIT
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [1:0] kind;
    logic [2:0] status;
    logic [7:0] dev;
    logic       cmd_wr;
    logic [3:0] ptr;
    logic [7:0] data;
    logic       resp_wr;
    resp_word_t resp;
    logic       rd_header;
    logic       rd_sel;
    logic [1:0] rd_len;
    logic [3:0] emit_len;
  } q_entry_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RESP_RD,
    BK_EMIT,
    BK_EMIT_END
  } back_state_t;

endpackage

### hdl/i2cmf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmf_ram
// Simple dual port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module i2cmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hdl/i2cmf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmf_fifo
// Short job queue between the framer front end and the mailbox back end.
// ----------------------------------------------------------------------------
module i2cmf_fifo import i2cmf_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output logic     empty,
  output logic     full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    count_nxt = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == CW'(DEPTH));

endmodule

### hdl/i2cmf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmf_front
// Framer front end: decodes each transaction, tracks packet and mailbox
// flags, and builds one job for the back end.
// ----------------------------------------------------------------------------
module i2cmf_front import i2cmf_pkg::*; #(
  parameter int DEVICES      = DEVICES_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  in_item_t              item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output q_entry_t              entry
);

  localparam int DEV_IDX_W        = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam logic [8:0] DEV_LIM  = 9'(DEVICES);
  localparam logic [3:0] PB_LIM   = 4'(PACKET_BYTES);

  logic [7:0]           busy_code_r, cksum_code_r;
  logic                 cmd_busy_r  [DEVICES];
  logic                 resp_full_r [DEVICES];
  logic [1:0]           resp_len_r  [DEVICES];

  logic [7:0]           cur_dev_r, cur_dev_nxt;
  logic [3:0]           ptr_r, ptr_nxt;
  logic [3:0]           exp_len_r, exp_len_nxt;
  logic [3:0]           exp_chk_r, exp_chk_nxt;
  logic [3:0]           run_chk_r, run_chk_nxt;
  logic                 next_addr_r, next_addr_nxt;
  logic                 hdr_pend_r, hdr_pend_nxt;
  logic                 hdr_send_r, hdr_send_nxt;
  logic                 discard_r, discard_nxt;

  logic                 set_busy, clr_busy, post_we, clr_full;
  logic [DEV_IDX_W-1:0] post_idx;
  logic [1:0]           post_len;
  logic [DEV_IDX_W-1:0] cur_idx, host_idx;
  logic                 cur_ok, host_ok, byte_ok;
  logic [3:0]           ptr_inc;
  logic [7:0]           prod;
  logic [3:0]           chk_sum;
  logic [1:0]           cur_len;

  always_comb begin
    cur_dev_nxt   = cur_dev_r;
    ptr_nxt       = ptr_r;
    exp_len_nxt   = exp_len_r;
    exp_chk_nxt   = exp_chk_r;
    run_chk_nxt   = run_chk_r;
    next_addr_nxt = next_addr_r;
    hdr_pend_nxt  = hdr_pend_r;
    hdr_send_nxt  = hdr_send_r;
    discard_nxt   = discard_r;
    set_busy      = 1'b0;
    clr_busy      = 1'b0;
    post_we       = 1'b0;
    clr_full      = 1'b0;
    post_len      = 2'd0;
    entry         = '0;
    entry.act     = ACT_NOTE;
    entry.kind    = RK_NONE;
    entry.status  = ST_OK;

    cur_ok   = ({1'b0, cur_dev_r} < DEV_LIM);
    host_ok  = ({6'b0, item.host_device} < DEV_LIM);
    byte_ok  = ({1'b0, item.bus_byte} < DEV_LIM);
    cur_idx  = DEV_IDX_W'(cur_dev_r);
    host_idx = DEV_IDX_W'(item.host_device);
    post_idx = cur_idx;
    ptr_inc  = ptr_r + 4'd1;
    prod     = 8'(item.bus_byte[3:0]) * 8'(ptr_inc);
    chk_sum  = run_chk_r + prod[3:0];
    cur_len  = resp_len_r[cur_idx];

    case (item.operation)
      OP_WRITE_REQ: begin
        next_addr_nxt = 1'b1;
      end
      OP_WRITE_DONE: begin
        if (next_addr_r) begin
          next_addr_nxt = 1'b0;
          cur_dev_nxt   = item.bus_byte;
          hdr_pend_nxt  = 1'b1;
          ptr_nxt       = 4'd0;
          run_chk_nxt   = 4'd0;
          discard_nxt   = !byte_ok;
          entry.status  = byte_ok ? ST_OK : ST_BAD_DEV;
        end else if (discard_r) begin
          hdr_pend_nxt = 1'b0;
          entry.status = cur_ok ? ST_OVERRUN : ST_BAD_DEV;
        end else if (!cur_ok) begin
          entry.status = ST_BAD_DEV;
        end else if (hdr_pend_r) begin
          hdr_pend_nxt = 1'b0;
          exp_len_nxt  = item.bus_byte[7:4];
          exp_chk_nxt  = item.bus_byte[3:0];
          run_chk_nxt  = 4'd0;
          if (item.bus_byte[7:4] == 4'd0 || item.bus_byte[7:4] > PB_LIM) begin
            discard_nxt  = 1'b1;
            entry.status = ST_OVERRUN;
          end
        end else if (cmd_busy_r[cur_idx]) begin
          post_we          = 1'b1;
          post_len         = 2'd2;
          hdr_send_nxt     = 1'b1;
          entry.dev        = cur_dev_r;
          entry.resp_wr    = 1'b1;
          entry.resp.byte0 = 8'd0;
          entry.resp.byte1 = busy_code_r;
          entry.resp.chk   = {busy_code_r[2:0], 1'b0};
          entry.status     = ST_BUSY;
        end else if (ptr_r >= exp_len_r || ptr_r >= PB_LIM) begin
          discard_nxt  = 1'b1;
          entry.status = ST_OVERRUN;
        end else begin
          entry.cmd_wr = 1'b1;
          entry.dev    = cur_dev_r;
          entry.ptr    = ptr_r;
          entry.data   = item.bus_byte;
          run_chk_nxt  = chk_sum;
          ptr_nxt      = ptr_inc;
          if (ptr_inc == exp_len_r) begin
            discard_nxt = 1'b1;
            if (chk_sum != exp_chk_r) begin
              post_we          = 1'b1;
              post_len         = 2'd2;
              hdr_send_nxt     = 1'b1;
              entry.resp_wr    = 1'b1;
              entry.resp.byte0 = 8'd0;
              entry.resp.byte1 = cksum_code_r;
              entry.resp.chk   = {cksum_code_r[2:0], 1'b0};
              entry.status     = ST_CKSUM;
            end else begin
              set_busy       = 1'b1;
              entry.act      = ACT_EMIT;
              entry.kind     = RK_COMMAND;
              entry.emit_len = exp_len_r;
            end
          end
        end
      end
      OP_READ_REQ: begin
        entry.kind = RK_BUS;
        entry.dev  = cur_dev_r;
        if (!cur_ok) begin
          entry.status = ST_BAD_DEV;
        end else if (!resp_full_r[cur_idx] || ptr_r >= {2'b00, cur_len}) begin
          entry.act = ACT_NOTE;
        end else if (hdr_send_r) begin
          hdr_send_nxt    = 1'b0;
          entry.act       = ACT_READ;
          entry.rd_header = 1'b1;
          entry.rd_len    = cur_len;
        end else begin
          entry.act    = ACT_READ;
          entry.rd_sel = ptr_r[0];
          ptr_nxt      = ptr_inc;
          if (ptr_inc == {2'b00, cur_len}) begin
            clr_full     = 1'b1;
            hdr_send_nxt = 1'b1;
          end
        end
      end
      OP_POST: begin
        if (!host_ok) begin
          entry.status = ST_BAD_DEV;
        end else begin
          post_we       = 1'b1;
          post_idx      = host_idx;
          hdr_send_nxt  = 1'b1;
          entry.dev     = 8'(item.host_device);
          entry.resp_wr = 1'b1;
          case (item.response_kind)
            RESP_ACK: begin
              post_len         = 2'd1;
              entry.resp.byte0 = ACK_BYTE;
            end
            RESP_DONE: begin
              post_len         = 2'd1;
              entry.resp.byte0 = DONE_BYTE;
            end
            RESP_ACK_DONE: begin
              post_len         = 2'd1;
              entry.resp.byte0 = ACK_DONE_BYTE;
            end
            default: begin
              post_len         = 2'd2;
              entry.resp.byte0 = 8'd0;
              entry.resp.byte1 = item.host_error_code;
              entry.resp.chk   = {item.host_error_code[2:0], 1'b0};
            end
          endcase
        end
      end
      OP_RELEASE: begin
        if (!host_ok) begin
          entry.status = ST_BAD_DEV;
        end else begin
          clr_busy = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_code_r  <= BUSY_CODE_RST;
      cksum_code_r <= CKSUM_CODE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BUSY_CODE:  busy_code_r  <= cfg_data;
        CFG_CKSUM_CODE: cksum_code_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_dev_r   <= '0;
      ptr_r       <= '0;
      exp_len_r   <= '0;
      exp_chk_r   <= '0;
      run_chk_r   <= '0;
      next_addr_r <= 1'b0;
      hdr_pend_r  <= 1'b0;
      hdr_send_r  <= 1'b1;
      discard_r   <= 1'b0;
    end else if (accept) begin
      cur_dev_r   <= cur_dev_nxt;
      ptr_r       <= ptr_nxt;
      exp_len_r   <= exp_len_nxt;
      exp_chk_r   <= exp_chk_nxt;
      run_chk_r   <= run_chk_nxt;
      next_addr_r <= next_addr_nxt;
      hdr_pend_r  <= hdr_pend_nxt;
      hdr_send_r  <= hdr_send_nxt;
      discard_r   <= discard_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEVICES; i++) begin
        cmd_busy_r[i]  <= 1'b0;
        resp_full_r[i] <= 1'b0;
        resp_len_r[i]  <= 2'd0;
      end
    end else if (accept) begin
      if (set_busy) begin
        cmd_busy_r[cur_idx] <= 1'b1;
      end
      if (clr_busy) begin
        cmd_busy_r[host_idx] <= 1'b0;
      end
      if (post_we) begin
        resp_full_r[post_idx] <= 1'b1;
        resp_len_r[post_idx]  <= post_len;
      end
      if (clr_full) begin
        resp_full_r[cur_idx] <= 1'b0;
      end
    end
  end

endmodule

### hdl/i2cmf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmf_back
// Mailbox back end: owns the command and response RAMs, runs one job at a
// time and drives the result strobe.
// ----------------------------------------------------------------------------
module i2cmf_back import i2cmf_pkg::*; #(
  parameter int DEVICES      = DEVICES_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  q_entry_t  head,
  input  logic      empty,
  output logic      pop,
  output logic      out_strobe,
  output out_item_t out_item
);

  localparam int DEV_IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int CMD_DEPTH = DEVICES * PACKET_BYTES;
  localparam int CMD_AW    = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
  localparam int RESP_W    = $bits(resp_word_t);

  back_state_t          state_r, state_nxt;
  q_entry_t             job_r, job_nxt;
  logic [3:0]           cnt_r, cnt_nxt;
  logic                 pend_r, pend_nxt;
  logic [3:0]           pend_idx_r, pend_idx_nxt;
  logic                 pend_last_r, pend_last_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 cmd_we;
  logic [CMD_AW-1:0]    cmd_waddr, cmd_raddr;
  logic [7:0]           cmd_rdata;
  logic                 resp_we;
  logic [DEV_IDX_W-1:0] resp_waddr, resp_raddr;
  resp_word_t           resp_rdata;
  logic [RESP_W-1:0]    resp_rbits;

  i2cmf_ram #(
    .WIDTH (8),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_ram (
    .clk   (clk),
    .we    (cmd_we),
    .waddr (cmd_waddr),
    .wdata (head.data),
    .raddr (cmd_raddr),
    .rdata (cmd_rdata)
  );

  i2cmf_ram #(
    .WIDTH (RESP_W),
    .DEPTH (DEVICES)
  ) u_resp_ram (
    .clk   (clk),
    .we    (resp_we),
    .waddr (resp_waddr),
    .wdata (head.resp),
    .raddr (resp_raddr),
    .rdata (resp_rbits)
  );

  assign resp_rdata = resp_word_t'(resp_rbits);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          case (head.act)
            ACT_READ: state_nxt = BK_RESP_RD;
            ACT_EMIT: state_nxt = BK_EMIT;
            default:  state_nxt = BK_IDLE;
          endcase
        end
      end
      BK_RESP_RD: state_nxt = BK_IDLE;
      BK_EMIT: begin
        if (cnt_r == job_r.emit_len - 4'd1) begin
          state_nxt = BK_EMIT_END;
        end
      end
      BK_EMIT_END: state_nxt = BK_IDLE;
      default:     state_nxt = BK_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    pop            = (state_r == BK_IDLE) && !empty;
    cmd_we         = pop && head.cmd_wr;
    cmd_waddr      = CMD_AW'(int'(head.dev) * PACKET_BYTES + int'(head.ptr));
    cmd_raddr      = CMD_AW'(int'(job_r.dev) * PACKET_BYTES + int'(cnt_r));
    resp_we        = pop && head.resp_wr;
    resp_waddr     = DEV_IDX_W'(head.dev);
    resp_raddr     = DEV_IDX_W'(head.dev);
    job_nxt        = pop ? head : job_r;
    cnt_nxt        = pop ? 4'd0 : cnt_r + 4'd1;
    pend_nxt       = (state_r == BK_EMIT);
    pend_idx_nxt   = cnt_r;
    pend_last_nxt  = (cnt_r == job_r.emit_len - 4'd1);
    out_strobe_nxt = 1'b0;
    out_item_nxt   = '0;

    if (pop && head.act == ACT_NOTE) begin
      out_strobe_nxt            = 1'b1;
      out_item_nxt.result_kind  = head.kind;
      out_item_nxt.last         = 1'b1;
      out_item_nxt.event_status = head.status;
    end

    if (state_r == BK_RESP_RD) begin
      out_strobe_nxt            = 1'b1;
      out_item_nxt.result_kind  = RK_BUS;
      out_item_nxt.last         = 1'b1;
      out_item_nxt.event_status = job_r.status;
      if (job_r.rd_header) begin
        out_item_nxt.read_data = {2'b00, job_r.rd_len, resp_rdata.chk};
      end else begin
        out_item_nxt.read_data = job_r.rd_sel ? resp_rdata.byte1 : resp_rdata.byte0;
      end
    end

    if (pend_r) begin
      out_strobe_nxt              = 1'b1;
      out_item_nxt.result_kind    = RK_COMMAND;
      out_item_nxt.command_device = job_r.dev[2:0];
      out_item_nxt.command_index  = pend_idx_r;
      out_item_nxt.command_byte   = cmd_rdata;
      out_item_nxt.last           = pend_last_r;
      out_item_nxt.event_status   = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BK_IDLE;
      pend_r       <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pend_r       <= pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    cnt_r       <= cnt_nxt;
    pend_idx_r  <= pend_idx_nxt;
    pend_last_r <= pend_last_nxt;
    out_item_r  <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

### hdl/i2c_slave_mailbox_framer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_mailbox_framer_unit
// I2C slave framer with per-device command and response mailboxes.
//
//   channel  handshake           payload            direction
//   in       start / busy        in_item (struct)   into block
//   out      out_strobe          out_item (struct)  out of block, one cycle
//   cfg      cfg_we              cfg_index/data     into block, no wait
//
// A transaction is taken when start is high and busy is low; busy rises
// only while the two-entry job queue is full.
// The back end reads the response RAM for a response byte read and the
// command RAM once per byte for a verified packet of n bytes; a status
// result is strobed in the cycle after its job is popped, a read byte
// after the response RAM read and the output register, and each command
// byte after its command RAM read, the pend register and the output register.
// Synchronous reset clears the queue, the framer flags and the busy/full
// bits; RAM contents are not cleared.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module i2c_slave_mailbox_framer_unit import i2cmf_pkg::*; #(
  parameter int DEVICES      = DEVICES_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  in_item_t              in_item,
  output logic                  out_strobe,
  output out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic     accept;
  logic     q_full, q_empty, q_pop;
  q_entry_t front_entry, q_head;

  assign accept = start && !q_full;
  assign busy   = q_full;

  i2cmf_front #(
    .DEVICES      (DEVICES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .entry     (front_entry)
  );

  i2cmf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (accept),
    .push_entry (front_entry),
    .pop        (q_pop),
    .head       (q_head),
    .empty      (q_empty),
    .full       (q_full)
  );

  i2cmf_back #(
    .DEVICES      (DEVICES),
    .PACKET_BYTES (PACKET_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // command bytes of one packet come back to back with rising index
  a_cmd_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.result_kind == RK_COMMAND && !out_item.last) |=>
      (out_strobe && out_item.result_kind == RK_COMMAND &&
       out_item.command_index == $past(out_item.command_index) + 4'd1))
    else $error("command packet broken");

  // every non-command result closes its transaction
  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.result_kind != RK_COMMAND) |-> out_item.last)
    else $error("single result without last");

  // nothing pending right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_strobe && !busy))
    else $error("activity after reset");

  // queue never pops while empty
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue underflow");

endmodule

### tb/i2c_slave_mailbox_framer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_mailbox_framer_checker
// Passive checker for the mailbox framer. It tracks the config writes and
// every accepted transaction, runs its own model of the framer state to
// queue the results each transaction must produce, and compares every
// strobed result against the oldest queued one.
// ----------------------------------------------------------------------------
module i2c_slave_mailbox_framer_checker import i2cmf_pkg::*; #(
  parameter int DEVICES      = DEVICES_DEF,
  parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  busy,
  input  in_item_t              in_item,
  input  logic                  out_strobe,
  input  out_item_t             out_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending,
  output int                    results_checked,
  output int                    packets_emitted
);

  logic [7:0] busy_code;
  logic [7:0] cksum_code;
  logic [7:0] cmd_mem    [DEVICES*PACKET_BYTES];
  logic       cmd_held   [DEVICES];
  logic [7:0] resp_mem   [DEVICES*2];
  logic [1:0] resp_len   [DEVICES];
  logic       resp_ready [DEVICES];
  logic [3:0] resp_sum   [DEVICES];
  logic [7:0] cur_dev;
  logic [3:0] ptr;
  logic [3:0] want_len;
  logic [3:0] want_sum;
  logic [3:0] run_sum;
  logic       addr_next;
  logic       hdr_next;
  logic       hdr_send;
  logic       dropping;

  out_item_t  results_due [$];
  out_item_t  oldest;
  int         errs    = 0;
  int         checked = 0;
  int         packets = 0;

  function automatic string show(out_item_t r);
    return $sformatf("kind %0d data %02h dev %0d idx %0d byte %02h last %0d status %0d",
                     r.result_kind, r.read_data, r.command_device, r.command_index,
                     r.command_byte, r.last, r.event_status);
  endfunction

  function automatic void clear_state();
    int d;
    busy_code  = BUSY_CODE_RST;
    cksum_code = CKSUM_CODE_RST;
    for (d = 0; d < DEVICES; d++) begin
      cmd_held[d]   = 1'b0;
      resp_len[d]   = 2'd0;
      resp_ready[d] = 1'b0;
    end
    cur_dev   = 8'd0;
    ptr       = 4'd0;
    want_len  = 4'd0;
    want_sum  = 4'd0;
    run_sum   = 4'd0;
    addr_next = 1'b0;
    hdr_next  = 1'b0;
    hdr_send  = 1'b1;
    dropping  = 1'b0;
    results_due.delete();
  endfunction

  // single status-only result
  function automatic void note(logic [2:0] st);
    out_item_t r;
    r = '0;
    r.result_kind  = RK_NONE;
    r.last         = 1'b1;
    r.event_status = st;
    results_due.push_back(r);
  endfunction

  function automatic void post_resp(int dev, logic [7:0] b0, logic [7:0] b1, int len);
    int s;
    resp_mem[dev*2] = b0;
    s = b0;
    if (len == 2) begin
      resp_mem[dev*2+1] = b1;
      s = s + b1 * 2;
    end
    resp_len[dev]   = 2'(len);
    resp_sum[dev]   = 4'(s);
    resp_ready[dev] = 1'b1;
    hdr_send        = 1'b1;
  endfunction

  function automatic void take_write(logic [7:0] b);
    int        dev;
    int        n;
    int        i;
    out_item_t r;
    dev = cur_dev;
    if (addr_next) begin
      addr_next = 1'b0;
      cur_dev   = b;
      hdr_next  = 1'b1;
      ptr       = 4'd0;
      run_sum   = 4'd0;
      dropping  = (b >= DEVICES);
      note((b >= DEVICES) ? ST_BAD_DEV : ST_OK);
    end else if (dropping) begin
      hdr_next = 1'b0;
      note((dev >= DEVICES) ? ST_BAD_DEV : ST_OVERRUN);
    end else if (dev >= DEVICES) begin
      note(ST_BAD_DEV);
    end else if (hdr_next) begin
      hdr_next = 1'b0;
      want_len = b[7:4];
      want_sum = b[3:0];
      run_sum  = 4'd0;
      if (want_len == 0 || want_len > PACKET_BYTES) begin
        dropping = 1'b1;
        note(ST_OVERRUN);
      end else begin
        note(ST_OK);
      end
    end else if (cmd_held[dev]) begin
      post_resp(dev, 8'h00, busy_code, 2);
      note(ST_BUSY);
    end else if (ptr >= want_len || ptr >= PACKET_BYTES) begin
      dropping = 1'b1;
      note(ST_OVERRUN);
    end else begin
      cmd_mem[dev*PACKET_BYTES + ptr] = b;
      run_sum = 4'(run_sum + b * (ptr + 1));
      ptr     = ptr + 4'd1;
      if (ptr != want_len) begin
        note(ST_OK);
      end else begin
        dropping = 1'b1;
        if (run_sum != want_sum) begin
          post_resp(dev, 8'h00, cksum_code, 2);
          note(ST_CKSUM);
        end else begin
          cmd_held[dev] = 1'b1;
          n = want_len;
          for (i = 0; i < n; i++) begin
            r = '0;
            r.result_kind    = RK_COMMAND;
            r.command_device = 3'(dev);
            r.command_index  = 4'(i);
            r.command_byte   = cmd_mem[dev*PACKET_BYTES + i];
            r.last           = (i == n - 1);
            r.event_status   = ST_OK;
            results_due.push_back(r);
          end
          packets++;
        end
      end
    end
  endfunction

  // reads share the write pointer
  function automatic void take_read();
    int        dev;
    int        len;
    out_item_t r;
    dev = cur_dev;
    r = '0;
    r.result_kind = RK_BUS;
    r.last        = 1'b1;
    if (dev >= DEVICES) begin
      r.event_status = ST_BAD_DEV;
    end else begin
      len = resp_len[dev];
      if (!resp_ready[dev] || ptr >= len) begin
        r.read_data = 8'h00;
      end else if (hdr_send) begin
        hdr_send    = 1'b0;
        r.read_data = {2'b00, resp_len[dev], resp_sum[dev]};
      end else begin
        r.read_data = resp_mem[dev*2 + ptr[0]];
        ptr = ptr + 4'd1;
        if (ptr == len) begin
          resp_ready[dev] = 1'b0;
          hdr_send        = 1'b1;
        end
      end
    end
    results_due.push_back(r);
  endfunction

  function automatic void frame_item(in_item_t it);
    int hd;
    hd = it.host_device;
    case (it.operation)
      OP_WRITE_REQ: begin
        addr_next = 1'b1;
        note(ST_OK);
      end
      OP_WRITE_DONE: take_write(it.bus_byte);
      OP_READ_REQ:   take_read();
      OP_POST: begin
        if (hd >= DEVICES) begin
          note(ST_BAD_DEV);
        end else begin
          case (it.response_kind)
            RESP_ACK:      post_resp(hd, ACK_BYTE, 8'h00, 1);
            RESP_DONE:     post_resp(hd, DONE_BYTE, 8'h00, 1);
            RESP_ACK_DONE: post_resp(hd, ACK_DONE_BYTE, 8'h00, 1);
            default:       post_resp(hd, 8'h00, it.host_error_code, 2);
          endcase
          note(ST_OK);
        end
      end
      OP_RELEASE: begin
        if (hd >= DEVICES) begin
          note(ST_BAD_DEV);
        end else begin
          cmd_held[hd] = 1'b0;
          note(ST_OK);
        end
      end
      default: note(ST_OK);
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BUSY_CODE) begin
          busy_code = cfg_data;
        end else if (cfg_index == CFG_CKSUM_CODE) begin
          cksum_code = cfg_data;
        end
      end
      if (start && !busy) begin
        frame_item(in_item);
      end
      if (out_strobe) begin
        if (results_due.size() == 0) begin
          errs++;
          if (errs <= 10) begin
            $display("tb: unexpected result %s", show(out_item));
          end
        end else begin
          oldest = results_due.pop_front();
          checked++;
          if (out_item !== oldest) begin
            errs++;
            if (errs <= 10) begin
              $display("tb: mismatch expected %s", show(oldest));
              $display("tb:          actual   %s", show(out_item));
            end
          end
        end
      end
    end
    fail_count      <= errs;
    pending         <= results_due.size();
    results_checked <= checked;
    packets_emitted <= packets;
  end

endmodule

### tb/i2c_slave_mailbox_framer_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_slave_mailbox_framer_unit_test
// Top of the framer testbench. Drives a short directed list covering the
// write, read and host paths and their error cases, then four random phases
// of framed write packets, mailbox reads, host posts, releases and noise,
// each phase with its own error codes; phases two and four add sender idle gaps. The checker
// beside the block does all prediction and comparison.
// ----------------------------------------------------------------------------
module i2c_slave_mailbox_framer_unit_test;
  import i2cmf_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASE_ITEMS  = 112;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  in_item_t              in_item;
  logic                  out_strobe;
  out_item_t             out_item;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;
  int results_checked;
  int packets_emitted;
  int cycles = 0;
  int sent   = 0;

  in_item_t plan [$];
  bit       addr_expected = 1'b0;
  bit       win_open      = 1'b0;
  bit       tainted       = 1'b0;

  always #10 clk = ~clk;

  i2c_slave_mailbox_framer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  i2c_slave_mailbox_framer_checker checker_i (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_item         (in_item),
    .out_strobe      (out_strobe),
    .out_item        (out_item),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .fail_count      (fail_count),
    .pending         (pending),
    .results_checked (results_checked),
    .packets_emitted (packets_emitted)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // a read inside an open write packet may move the shared pointer past
  // unwritten command slots, so later payload bytes restart with an address
  task automatic add(logic [2:0] op, logic [7:0] b, logic [2:0] hdev,
                     logic [1:0] kind, logic [7:0] herr);
    in_item_t it;
    if (op == OP_WRITE_DONE && !addr_expected && tainted) begin
      op = OP_WRITE_REQ;
    end
    if (op != OP_WRITE_DONE) begin
      b = 8'($urandom);
    end
    if (op != OP_POST && op != OP_RELEASE) begin
      hdev = 3'($urandom);
      kind = 2'($urandom);
      herr = 8'($urandom);
    end
    case (op)
      OP_WRITE_REQ: addr_expected = 1'b1;
      OP_WRITE_DONE: begin
        if (addr_expected) begin
          addr_expected = 1'b0;
          win_open      = 1'b1;
          tainted       = 1'b0;
        end
      end
      OP_READ_REQ: begin
        if (win_open) begin
          tainted = 1'b1;
        end
      end
      default: ;
    endcase
    it.operation       = op;
    it.bus_byte        = b;
    it.host_device     = hdev;
    it.response_kind   = kind;
    it.host_error_code = herr;
    plan.push_back(it);
  endtask

  task automatic add_packet(logic [7:0] dev, int size, bit good, int extra);
    logic [7:0] payload [$];
    logic [7:0] b;
    int         sum;
    int         i;
    sum = 0;
    for (i = 0; i < ((size == 0) ? 1 : size); i++) begin
      b = 8'($urandom);
      payload.push_back(b);
      sum = sum + b * (i + 1);
    end
    if (!good) begin
      sum = sum ^ $urandom_range(15, 1);
    end
    add(OP_WRITE_REQ, 8'h00, 3'd0, RESP_ACK, 8'h00);
    add(OP_WRITE_DONE, dev, 3'd0, RESP_ACK, 8'h00);
    add(OP_WRITE_DONE, {4'(size), 4'(sum)}, 3'd0, RESP_ACK, 8'h00);
    foreach (payload[k]) begin
      add(OP_WRITE_DONE, payload[k], 3'd0, RESP_ACK, 8'h00);
    end
    repeat (extra) add(OP_WRITE_DONE, 8'($urandom), 3'd0, RESP_ACK, 8'h00);
  endtask

  task automatic add_read(logic [7:0] dev, int n);
    add(OP_WRITE_REQ, 8'h00, 3'd0, RESP_ACK, 8'h00);
    add(OP_WRITE_DONE, dev, 3'd0, RESP_ACK, 8'h00);
    repeat (n) add(OP_READ_REQ, 8'h00, 3'd0, RESP_ACK, 8'h00);
    add(OP_READ_DONE, 8'h00, 3'd0, RESP_ACK, 8'h00);
  endtask

  function automatic logic [7:0] pick_dev();
    if ($urandom_range(9) == 0) begin
      return 8'($urandom_range(255, DEVICES_DEF));
    end
    return 8'($urandom_range(DEVICES_DEF - 1));
  endfunction

  // mostly well formed bus sequences, some host traffic, some noise
  task automatic plan_random(int n);
    int r;
    int size;
    while (plan.size() < n) begin
      r = $urandom_range(99);
      if (r < 40) begin
        size = $urandom_range(99);
        size = (size < 10) ? 15 : (size < 18) ? 0 : $urandom_range(4, 1);
        add_packet(pick_dev(), size, $urandom_range(99) < 80,
                   ($urandom_range(99) < 15) ? $urandom_range(2, 1) : 0);
      end else if (r < 55) begin
        add(OP_RELEASE, 8'h00, 3'($urandom), RESP_ACK, 8'h00);
      end else if (r < 70) begin
        add(OP_POST, 8'h00, 3'($urandom), 2'($urandom), 8'($urandom));
      end else if (r < 85) begin
        add_read(pick_dev(), $urandom_range(4, 1));
      end else begin
        repeat ($urandom_range(3, 1)) begin
          add(3'($urandom), 8'($urandom), 3'($urandom), 2'($urandom), 8'($urandom));
        end
      end
    end
  endtask

  task automatic run_plan(int idle_pct);
    int gap;
    foreach (plan[i]) begin
      gap = 0;
      while ($urandom_range(99) < idle_pct && gap < 40) gap++;
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      start   <= 1'b1;
      in_item <= plan[i];
      @(posedge clk);
      while (busy) @(posedge clk);
      sent++;
    end
    start <= 1'b0;
    plan.delete();
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_codes(logic [7:0] busy_v, logic [7:0] cksum_v);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_BUSY_CODE;
    cfg_data  <= busy_v;
    @(posedge clk);
    cfg_index <= CFG_CKSUM_CODE;
    cfg_data  <= cksum_v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    rst_n     = 1'b0;
    start     = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: host posts, mailbox read out, good packet with overrun,
    // busy slot, bad checksum, bad device, size-zero header
    add(OP_POST, 8'h00, 3'd0, RESP_ACK, 8'h00);
    add_read(8'd0, 3);
    add_packet(8'd1, 2, 1'b1, 1);
    add_packet(8'd1, 1, 1'b1, 0);
    add_packet(8'd2, 1, 1'b0, 0);
    add_packet(8'hFF, 1, 1'b1, 0);
    add(OP_READ_REQ, 8'h00, 3'd0, RESP_ACK, 8'h00);
    add(OP_WRITE_REQ, 8'h00, 3'd0, RESP_ACK, 8'h00);
    add(OP_WRITE_DONE, 8'd3, 3'd0, RESP_ACK, 8'h00);
    add(OP_WRITE_DONE, 8'h05, 3'd0, RESP_ACK, 8'h00);
    add(OP_RELEASE, 8'h00, 3'd1, RESP_ACK, 8'h00);
    add(OP_POST, 8'h00, 3'd7, RESP_ERROR, 8'hFF);
    run_plan(0);

    for (int phase = 1; phase <= 4; phase++) begin
      drain();
      case (phase)
        1:       set_codes(8'h00, 8'hFF);
        2:       set_codes(8'hFF, 8'h00);
        default: set_codes(8'($urandom), 8'($urandom));
      endcase
      plan_random(PHASE_ITEMS);
      case (phase)
        2:       run_plan(82);
        4:       run_plan(16);
        default: run_plan(0);
      endcase
    end
    drain();

    $display("tb: %0d transactions over a directed list and four random phases",
             sent);
    $display("tb: %0d results checked, %0d command packets emitted, %0d mismatches",
             results_checked, packets_emitted, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hdl/i2cmf_pkg.sv
hdl/i2cmf_ram.sv
hdl/i2cmf_fifo.sv
hdl/i2cmf_front.sv
hdl/i2cmf_back.sv
hdl/i2c_slave_mailbox_framer_unit.sv
tb/i2c_slave_mailbox_framer_checker.sv
tb/i2c_slave_mailbox_framer_unit_test.sv
